[design/mefm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mefm_pkg: shared types and constants
// command and write beat formats, opcode codes, shadow slot map, note tables
// ----------------------------------------------------------------------------
package mefm_pkg;

   // event opcodes
   localparam logic [2:0] OP_RAW       = 3'd0;
   localparam logic [2:0] OP_NOTE_ON   = 3'd1;
   localparam logic [2:0] OP_NOTE_OFF  = 3'd2;
   localparam logic [2:0] OP_DRUM_ON   = 3'd3;
   localparam logic [2:0] OP_DRUM_OFF  = 3'd4;
   localparam logic [2:0] OP_PARAM     = 3'd5;

   // shadow slots: only registers that are ever read back are kept
   localparam int SLOT_COUNT = 13;
   localparam int SLOT_W     = $clog2(SLOT_COUNT);

   localparam logic [SLOT_W-1:0] SLOT_TEST   = 4'd0;   // 0x08
   localparam logic [SLOT_W-1:0] SLOT_RHYTHM = 4'd1;   // 0xBD
   localparam logic [SLOT_W-1:0] SLOT_FBCON  = 4'd2;   // 0xC0
   localparam logic [SLOT_W-1:0] SLOT_CHAR   = 4'd3;   // 0x20, 0x23
   localparam logic [SLOT_W-1:0] SLOT_LEVEL  = 4'd5;   // 0x40, 0x43
   localparam logic [SLOT_W-1:0] SLOT_AD     = 4'd7;   // 0x60, 0x63
   localparam logic [SLOT_W-1:0] SLOT_SR     = 4'd9;   // 0x80, 0x83
   localparam logic [SLOT_W-1:0] SLOT_WAVE   = 4'd11;  // 0xE0, 0xE3

   localparam logic [7:0] SLOT_ADDR [SLOT_COUNT] = '{
      8'h08, 8'hBD, 8'hC0, 8'h20, 8'h23, 8'h40, 8'h43,
      8'h60, 8'h63, 8'h80, 8'h83, 8'hE0, 8'hE3
   };

   // one classified event, as the back end carries it out
   typedef struct packed {
      logic              rmw;      // first write merges with the shadow
      logic [SLOT_W-1:0] slot;
      logic [7:0]        addr0;
      logic [7:0]        keep0;    // shadow bits kept on merge
      logic [7:0]        bits0;    // bits or'd in (or plain data)
      logic              second;   // a second write follows
      logic [7:0]        addr1;
      logic [7:0]        data1;
   } cmd_type;

   // one register write beat
   typedef struct packed {
      logic [7:0] addr;
      logic [7:0] data;
      logic       last;
   } wr_type;

   // frequency number per semitone
   function automatic logic [8:0] fnum_lookup(input logic [3:0] semi);
      logic [8:0] f;
      unique case (semi)
         4'd0:    f = 9'd172;
         4'd1:    f = 9'd183;
         4'd2:    f = 9'd194;
         4'd3:    f = 9'd205;
         4'd4:    f = 9'd217;
         4'd5:    f = 9'd230;
         4'd6:    f = 9'd244;
         4'd7:    f = 9'd258;
         4'd8:    f = 9'd274;
         4'd9:    f = 9'd290;
         4'd10:   f = 9'd307;
         4'd11:   f = 9'd326;
         default: f = 9'd172;
      endcase
      return f;
   endfunction

   // percussion note to rhythm bit, hi-hat for anything unmapped
   function automatic logic [2:0] drum_lookup(input logic [6:0] note);
      logic [2:0] b;
      unique case (note)
         7'd35, 7'd36:                              b = 3'd4;
         7'd38, 7'd40:                              b = 3'd3;
         7'd41, 7'd43, 7'd45, 7'd47, 7'd48, 7'd50:  b = 3'd2;
         7'd49, 7'd51, 7'd52, 7'd55, 7'd57, 7'd59:  b = 3'd1;
         default:                                   b = 3'd0;
      endcase
      return b;
   endfunction

endpackage

[design/mefm_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mefm_fifo: two-entry queue
// decouples producer and consumer, full and empty flags from an occupancy count
// ----------------------------------------------------------------------------
module mefm_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[design/mefm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mefm_front: event classifier
// turns one music event into a write command, flags events that write nothing
// ----------------------------------------------------------------------------
module mefm_front
   import mefm_pkg::*;
#(
   parameter int VOICE_COUNT = 6
) (
   input  logic [2:0] opcode,
   input  logic [3:0] voice_channel,
   input  logic [6:0] note_number,
   input  logic [6:0] param_number,
   input  logic [7:0] param_value,
   input  logic [7:0] raw_addr,
   input  logic [7:0] raw_data,
   output cmd_type    cmd,
   output logic       has_write
);
   // controller numbers; operator pairs are the even number and the odd one
   localparam logic [6:0] P_FREQ      = 7'd1;
   localparam logic [6:0] P_CSM       = 7'd10;
   localparam logic [6:0] P_AM_DEPTH  = 7'd11;
   localparam logic [6:0] P_VIB_DEPTH = 7'd12;
   localparam logic [6:0] P_FEEDBACK  = 7'd13;
   localparam logic [6:0] P_CONNECT   = 7'd14;
   localparam logic [6:0] P_TREMOLO   = 7'd20;
   localparam logic [6:0] P_VIBRATO   = 7'd22;
   localparam logic [6:0] P_MAINTAIN  = 7'd24;
   localparam logic [6:0] P_MULT      = 7'd26;
   localparam logic [6:0] P_TOTAL_LVL = 7'd28;
   localparam logic [6:0] P_ATTACK    = 7'd30;
   localparam logic [6:0] P_DECAY     = 7'd32;
   localparam logic [6:0] P_SUST_LVL  = 7'd34;
   localparam logic [6:0] P_RELEASE   = 7'd36;
   localparam logic [6:0] P_WAVEFORM  = 7'd38;

   // note / 12 by reciprocal, exact over seven-bit notes
   localparam logic [12:0] DIV12_MUL   = 13'd43;
   localparam int          DIV12_SHIFT = 9;

   logic [3:0]  chan_lut [16];
   logic [3:0]  chan;
   logic [12:0] prod;
   logic [3:0]  octave;
   logic [3:0]  semi;
   logic [8:0]  fnum;
   logic [7:0]  drum_mask;
   logic        flag;
   logic [7:0]  op_ofs;
   logic [SLOT_W-1:0] op_slot;

   for (genvar i = 0; i < 16; i++) begin : g_chan
      assign chan_lut[i] = 4'(i % VOICE_COUNT);
   end

   assign chan      = chan_lut[voice_channel];
   assign prod      = 13'(note_number) * DIV12_MUL;
   assign octave    = prod[DIV12_SHIFT+3:DIV12_SHIFT];
   assign semi      = 4'(note_number - 7'(octave) * 7'd12);
   assign fnum      = fnum_lookup(semi);
   assign drum_mask = 8'(1) << drum_lookup(note_number);
   assign flag      = (param_value != 8'd0);
   assign op_ofs    = param_number[0] ? 8'h03 : 8'h00;
   assign op_slot   = SLOT_W'(param_number[0]);

   always_comb begin
      cmd       = '0;
      has_write = 1'b1;
      unique case (opcode)
         OP_RAW: begin
            cmd.addr0 = raw_addr;
            cmd.bits0 = raw_data;
         end
         OP_NOTE_ON: begin
            cmd.addr0  = 8'hA0 + 8'(chan);
            cmd.bits0  = fnum[7:0];
            cmd.second = 1'b1;
            cmd.addr1  = 8'hB0 + 8'(chan);
            cmd.data1  = {2'b00, 1'b1, octave[2:0], 1'b0, fnum[8]};
         end
         OP_NOTE_OFF: begin
            cmd.addr0 = 8'hB0 + 8'(chan);
            cmd.bits0 = 8'h00;
         end
         OP_DRUM_ON: begin
            cmd.rmw   = 1'b1;
            cmd.slot  = SLOT_RHYTHM;
            cmd.addr0 = 8'hBD;
            cmd.keep0 = 8'hE0;
            cmd.bits0 = drum_mask;
         end
         OP_DRUM_OFF: begin
            cmd.rmw   = 1'b1;
            cmd.slot  = SLOT_RHYTHM;
            cmd.addr0 = 8'hBD;
            cmd.keep0 = 8'hE0 | ~drum_mask;
            cmd.bits0 = 8'h00;
         end
         OP_PARAM: begin
            cmd.rmw = 1'b1;
            unique case (param_number)
               P_FREQ: begin
                  cmd.rmw    = 1'b0;
                  cmd.addr0  = 8'hA3;
                  cmd.bits0  = param_value;
                  cmd.second = 1'b1;
                  cmd.addr1  = 8'hB3;
                  cmd.data1  = 8'h31;
               end
               P_CSM: begin
                  cmd.slot = SLOT_TEST;   cmd.addr0 = 8'h08;
                  cmd.keep0 = 8'h7F;      cmd.bits0 = {flag, 7'd0};
               end
               P_AM_DEPTH: begin
                  cmd.slot = SLOT_RHYTHM; cmd.addr0 = 8'hBD;
                  cmd.keep0 = 8'h7F;      cmd.bits0 = {flag, 7'd0};
               end
               P_VIB_DEPTH: begin
                  cmd.slot = SLOT_RHYTHM; cmd.addr0 = 8'hBD;
                  cmd.keep0 = 8'hBF;      cmd.bits0 = {1'b0, flag, 6'd0};
               end
               P_FEEDBACK: begin
                  cmd.slot = SLOT_FBCON;  cmd.addr0 = 8'hC0;
                  cmd.keep0 = 8'hF1;      cmd.bits0 = {4'd0, param_value[2:0], 1'b0};
               end
               P_CONNECT: begin
                  cmd.slot = SLOT_FBCON;  cmd.addr0 = 8'hC0;
                  cmd.keep0 = 8'hFE;      cmd.bits0 = {7'd0, flag};
               end
               P_TREMOLO, P_TREMOLO | 7'd1: begin
                  cmd.slot = SLOT_CHAR + op_slot;   cmd.addr0 = 8'h20 + op_ofs;
                  cmd.keep0 = 8'h7F;      cmd.bits0 = {flag, 7'd0};
               end
               P_VIBRATO, P_VIBRATO | 7'd1: begin
                  cmd.slot = SLOT_CHAR + op_slot;   cmd.addr0 = 8'h20 + op_ofs;
                  cmd.keep0 = 8'hBF;      cmd.bits0 = {1'b0, flag, 6'd0};
               end
               P_MAINTAIN, P_MAINTAIN | 7'd1: begin
                  cmd.slot = SLOT_CHAR + op_slot;   cmd.addr0 = 8'h20 + op_ofs;
                  cmd.keep0 = 8'hDF;      cmd.bits0 = {2'd0, flag, 5'd0};
               end
               P_MULT, P_MULT | 7'd1: begin
                  cmd.slot = SLOT_CHAR + op_slot;   cmd.addr0 = 8'h20 + op_ofs;
                  cmd.keep0 = 8'hF0;      cmd.bits0 = {4'd0, param_value[3:0]};
               end
               P_TOTAL_LVL, P_TOTAL_LVL | 7'd1: begin
                  cmd.slot = SLOT_LEVEL + op_slot;  cmd.addr0 = 8'h40 + op_ofs;
                  cmd.keep0 = 8'hC0;      cmd.bits0 = {2'd0, param_value[5:0]};
               end
               P_ATTACK, P_ATTACK | 7'd1: begin
                  cmd.slot = SLOT_AD + op_slot;     cmd.addr0 = 8'h60 + op_ofs;
                  cmd.keep0 = 8'h0F;      cmd.bits0 = {param_value[3:0], 4'd0};
               end
               P_DECAY, P_DECAY | 7'd1: begin
                  cmd.slot = SLOT_AD + op_slot;     cmd.addr0 = 8'h60 + op_ofs;
                  cmd.keep0 = 8'hF0;      cmd.bits0 = {4'd0, param_value[3:0]};
               end
               P_SUST_LVL, P_SUST_LVL | 7'd1: begin
                  cmd.slot = SLOT_SR + op_slot;     cmd.addr0 = 8'h80 + op_ofs;
                  cmd.keep0 = 8'h0F;      cmd.bits0 = {param_value[3:0], 4'd0};
               end
               P_RELEASE, P_RELEASE | 7'd1: begin
                  cmd.slot = SLOT_SR + op_slot;     cmd.addr0 = 8'h80 + op_ofs;
                  cmd.keep0 = 8'hF0;      cmd.bits0 = {4'd0, param_value[3:0]};
               end
               P_WAVEFORM, P_WAVEFORM | 7'd1: begin
                  cmd.slot = SLOT_WAVE + op_slot;   cmd.addr0 = 8'hE0 + op_ofs;
                  cmd.keep0 = 8'hFC;      cmd.bits0 = {6'd0, param_value[1:0]};
               end
               default: begin
                  cmd.rmw   = 1'b0;
                  has_write = 1'b0;
               end
            endcase
         end
         default: begin
            has_write = 1'b0;
         end
      endcase
   end

endmodule

[design/mefm_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mefm_back: write engine
// issues one write per cycle unless stalled, merges fields with the register shadow
// ----------------------------------------------------------------------------
module mefm_back
   import mefm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  logic    cmd_empty,
   output logic    cmd_pop,
   output wr_type  wr,
   output logic    wr_push,
   input  logic    wr_full
);
   logic [7:0] shadow_ff [SLOT_COUNT];
   logic [7:0] shadow_in [SLOT_COUNT];
   logic       phase_ff, phase_in;
   logic [7:0] merged;

   assign merged  = cmd.rmw ? ((shadow_ff[cmd.slot] & cmd.keep0) | cmd.bits0) : cmd.bits0;
   assign wr_push = ~cmd_empty & ~wr_full;

   always_comb begin
      if (phase_ff) begin
         wr.addr = cmd.addr1;
         wr.data = cmd.data1;
         wr.last = 1'b1;
      end else begin
         wr.addr = cmd.addr0;
         wr.data = merged;
         wr.last = ~cmd.second;
      end
   end

   assign cmd_pop = wr_push & wr.last;

   always_comb begin
      phase_in = phase_ff;
      if (wr_push) begin
         phase_in = ~wr.last;
      end
   end

   // every issued write to a shadowed address lands in the shadow slot at its address
   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         shadow_in[i] = shadow_ff[i];
         if (wr_push && (wr.addr == SLOT_ADDR[i])) begin
            shadow_in[i] = wr.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            shadow_ff[i] <= 8'h00;
         end
      end else begin
         phase_ff <= phase_in;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            shadow_ff[i] <= shadow_in[i];
         end
      end
   end

   // second beat only pending against a two-write command
   a_phase_cmd: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (!cmd_empty && cmd.second))
      else $error("second beat pending without a two-write command");

   // a non-final beat is always followed by its partner
   a_pair: assert property (@(posedge clock) disable iff (reset)
      (wr_push && !wr.last) |=> phase_ff)
      else $error("first of two beats issued but second not pending");

   // rhythm register shadow follows its last write
   a_rhythm: assert property (@(posedge clock) disable iff (reset)
      (wr_push && wr.addr == 8'hBD) |=> (shadow_ff[SLOT_RHYTHM] == $past(wr.data)))
      else $error("rhythm shadow missed a write");

   // a command leaves the queue only on its final beat
   a_pop_last: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (wr_push && (phase_ff || !cmd.second)))
      else $error("command retired before its last beat");

endmodule

[design/music_event_to_fm_register_writes.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// music_event_to_fm_register_writes: music events to FM register writes
// classifies note, drum, parameter and raw events into one or two address /
// data beats, keeping a shadow of the registers that fields are merged into
// ----------------------------------------------------------------------------
//
//  channel   direction   handshake            payload
//  req_      in          req_push / req_full  opcode, channel, note, param, raw
//  rsp_      out         rsp_pop / rsp_empty  reg_addr, reg_data, last_write
//
//  - the write engine issues one beat per cycle while the output queue has room: raw,
//    note off, drum and field events give one beat, note on and the frequency parameter two
//  - an accepted event passes the command queue and the engine to reach the rsp_ queue
//  - events that cause no write are taken and dropped at the front
//  - reset is synchronous; the shadow is cleared in the same cycle
//  - two-entry queues sit between front and engine and on the output, so
//    either side may stall until the queues fill without stopping the other
//
module music_event_to_fm_register_writes
   import mefm_pkg::*;
#(
   parameter int VOICE_COUNT = 6
) (
   input  logic       clock,
   input  logic       reset,
   // event beats
   input  logic       req_push,
   output logic       req_full,
   input  logic [2:0] req_opcode,
   input  logic [3:0] req_voice_channel,
   input  logic [6:0] req_note_number,
   input  logic [6:0] req_param_number,
   input  logic [7:0] req_param_value,
   input  logic [7:0] req_raw_addr,
   input  logic [7:0] req_raw_data,
   // register write beats
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_reg_addr,
   output logic [7:0] rsp_reg_data,
   output logic       rsp_last_write
);
   cmd_type front_cmd;
   logic    front_has_write;
   logic    cmd_full;
   logic    cmd_push;
   cmd_type head_cmd;
   logic    cmd_empty;
   logic    cmd_pop;
   wr_type  eng_wr;
   logic    eng_push;
   logic    out_full;
   wr_type  out_wr;

   // front: decode the event straight into the command queue
   mefm_front #(
      .VOICE_COUNT (VOICE_COUNT)
   ) u_front (
      .opcode        (req_opcode),
      .voice_channel (req_voice_channel),
      .note_number   (req_note_number),
      .param_number  (req_param_number),
      .param_value   (req_param_value),
      .raw_addr      (req_raw_addr),
      .raw_data      (req_raw_data),
      .cmd           (front_cmd),
      .has_write     (front_has_write)
   );

   assign req_full = cmd_full;
   assign cmd_push = req_push & ~cmd_full & front_has_write;

   // command queue between classifier and engine
   mefm_fifo #(
      .WIDTH ($bits(cmd_type))
   ) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (front_cmd),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (head_cmd),
      .empty   (cmd_empty)
   );

   // engine: shadow merge and beat sequencing
   mefm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (head_cmd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .wr        (eng_wr),
      .wr_push   (eng_push),
      .wr_full   (out_full)
   );

   // output queue, parts the engine from the consumer
   mefm_fifo #(
      .WIDTH ($bits(wr_type))
   ) u_out_q (
      .clock   (clock),
      .reset   (reset),
      .push    (eng_push),
      .wr_data (eng_wr),
      .full    (out_full),
      .pop     (rsp_pop),
      .rd_data (out_wr),
      .empty   (rsp_empty)
   );

   assign rsp_reg_addr   = out_wr.addr;
   assign rsp_reg_data   = out_wr.data;
   assign rsp_last_write = out_wr.last;

endmodule
